// ----- design/mer_pkg.sv -----
package mer_pkg;

	// Kind of a queued transaction, decided in the front part
	typedef enum logic {
		KIND_START = 1'b0,
		KIND_STEP  = 1'b1
	} kind_t;

	// Status of the back part, seen by the top level
	typedef struct packed {
		logic idle;   // sequencer waits for the next queued transaction
		logic emit;   // result register loads this cycle
	} status_t;

	// Queue between the front and the back part
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

endpackage

// ----- design/midpoint_ellipse_rasterizer_core.sv -----
// Channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_stall    | operation, center_x, center_y, radius_x, radius_y
// output   | out_valid / out_stall  | q1_x..q4_y, points_valid, done_res
//
// States: a start runs LD1..LD3; a region-one step CK2, CK3, UP2, UP3;
//   a region-two step UP2, UP3; a crossing step CK2, CK3, EN2..EN7, UP2, UP3; a step
//   after the arc FIN; a single shared multiplier, one registered product a cycle.
// Reset: arst_n clears the queue and the sequencer; steps before any start report done.
// Stalls: a two-entry queue keeps the input side moving while the back part works;
//   a result register lets the back part take the next transaction under out_stall.
module midpoint_ellipse_rasterizer_core #(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0]        radius_x,
	input  logic [RADIUS_BITS-1:0]        radius_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS:0]    q1_x,
	output logic signed [COORD_BITS:0]    q1_y,
	output logic signed [COORD_BITS:0]    q2_x,
	output logic signed [COORD_BITS:0]    q2_y,
	output logic signed [COORD_BITS:0]    q3_x,
	output logic signed [COORD_BITS:0]    q3_y,
	output logic signed [COORD_BITS:0]    q4_x,
	output logic signed [COORD_BITS:0]    q4_y,
	output logic                          points_valid,
	output logic                          done_res
);
	import mer_pkg::*;

	// Queue head, seen by the back part
	logic                          head_valid;
	kind_t                         head_kind;
	logic signed [COORD_BITS-1:0]  head_center_x;
	logic signed [COORD_BITS-1:0]  head_center_y;
	logic [RADIUS_BITS-1:0]        head_radius_x;
	logic [RADIUS_BITS-1:0]        head_radius_y;
	logic                          pop;
	status_t                       status;

	// Front: accept transactions, tag start or step, hold them in the queue
	mer_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius_x      (radius_x),
		.radius_y      (radius_y),
		.pop           (pop),
		.head_valid    (head_valid),
		.head_kind     (head_kind),
		.head_center_x (head_center_x),
		.head_center_y (head_center_y),
		.head_radius_x (head_radius_x),
		.head_radius_y (head_radius_y)
	);

	// Back: load geometry, test the region, advance the decision variable,
	// drive the result register
	mer_back #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_kind     (head_kind),
		.head_center_x (head_center_x),
		.head_center_y (head_center_y),
		.head_radius_x (head_radius_x),
		.head_radius_y (head_radius_y),
		.pop           (pop),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.q1_x          (q1_x),
		.q1_y          (q1_y),
		.q2_x          (q2_x),
		.q2_y          (q2_y),
		.q3_x          (q3_x),
		.q3_y          (q3_y),
		.q4_x          (q4_x),
		.q4_y          (q4_y),
		.points_valid  (points_valid),
		.done_res      (done_res)
	);

`ifndef ASSERT_OFF
	// Never pop an empty queue
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	// Take a new transaction only from the idle sequencer
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.idle)
		else $error("queue popped while sequencer busy");

	// A loaded result shows on the output in the next cycle
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit |=> out_valid)
		else $error("loaded result not presented");

	// A result without points is always a finished arc
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !points_valid) |-> done_res)
		else $error("result without points not marked done");
`endif

endmodule

// ----- design/mer_front.sv -----
module mer_front #(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0]        radius_x,
	input  logic [RADIUS_BITS-1:0]        radius_y,
	input  logic                          pop,
	output logic                          head_valid,
	output mer_pkg::kind_t                head_kind,
	output logic signed [COORD_BITS-1:0]  head_center_x,
	output logic signed [COORD_BITS-1:0]  head_center_y,
	output logic [RADIUS_BITS-1:0]        head_radius_x,
	output logic [RADIUS_BITS-1:0]        head_radius_y
);
	import mer_pkg::*;

	kind_t                         kind_q [Q_DEPTH];
	logic signed [COORD_BITS-1:0]  cx_q   [Q_DEPTH];
	logic signed [COORD_BITS-1:0]  cy_q   [Q_DEPTH];
	logic [RADIUS_BITS-1:0]        rx_q   [Q_DEPTH];
	logic [RADIUS_BITS-1:0]        ry_q   [Q_DEPTH];

	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] count_q;
	logic                  push;
	kind_t                 in_kind;

	assign in_stall   = (count_q == Q_CNT_BITS'(Q_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign in_kind    = operation ? KIND_STEP : KIND_START;

	assign head_kind     = kind_q[rd_ptr_q];
	assign head_center_x = cx_q[rd_ptr_q];
	assign head_center_y = cy_q[rd_ptr_q];
	assign head_radius_x = rx_q[rd_ptr_q];
	assign head_radius_y = ry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Payload: no reset
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= in_kind;
			cx_q[wr_ptr_q]   <= center_x;
			cy_q[wr_ptr_q]   <= center_y;
			rx_q[wr_ptr_q]   <= radius_x;
			ry_q[wr_ptr_q]   <= radius_y;
		end
	end

endmodule

// ----- design/mer_back.sv -----
module mer_back #(
	parameter int COORD_BITS  = 11,
	parameter int RADIUS_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  mer_pkg::kind_t                head_kind,
	input  logic signed [COORD_BITS-1:0]  head_center_x,
	input  logic signed [COORD_BITS-1:0]  head_center_y,
	input  logic [RADIUS_BITS-1:0]        head_radius_x,
	input  logic [RADIUS_BITS-1:0]        head_radius_y,
	output logic                          pop,
	output mer_pkg::status_t              status,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS:0]    q1_x,
	output logic signed [COORD_BITS:0]    q1_y,
	output logic signed [COORD_BITS:0]    q2_x,
	output logic signed [COORD_BITS:0]    q2_y,
	output logic signed [COORD_BITS:0]    q3_x,
	output logic signed [COORD_BITS:0]    q3_y,
	output logic signed [COORD_BITS:0]    q4_x,
	output logic signed [COORD_BITS:0]    q4_y,
	output logic                          points_valid,
	output logic                          done_res
);
	import mer_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int R   = RADIUS_BITS;
	localparam int XW  = R + 1;                      // step x (unsigned), step y (signed)
	localparam int R2W = 2 * R;                      // squared semi-axis
	localparam int AW  = 3 * R + 3;                  // multiplier operand a, signed
	localparam int BW  = R + 4;                      // multiplier operand b, signed
	localparam int PW  = AW + BW;                    // product
	localparam int DW  = 4 * R + 8;                  // decision variable times four
	localparam int SW  = ((C > R + 2) ? C : R + 2) + 1;
	localparam int OW  = C + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LD1  = 4'd1;
	localparam logic [3:0] ST_LD2  = 4'd2;
	localparam logic [3:0] ST_LD3  = 4'd3;
	localparam logic [3:0] ST_CK2  = 4'd4;
	localparam logic [3:0] ST_CK3  = 4'd5;
	localparam logic [3:0] ST_EN2  = 4'd6;
	localparam logic [3:0] ST_EN3  = 4'd7;
	localparam logic [3:0] ST_EN4  = 4'd8;
	localparam logic [3:0] ST_EN5  = 4'd9;
	localparam logic [3:0] ST_EN6  = 4'd10;
	localparam logic [3:0] ST_EN7  = 4'd11;
	localparam logic [3:0] ST_UP2  = 4'd12;
	localparam logic [3:0] ST_UP3  = 4'd13;
	localparam logic [3:0] ST_FIN  = 4'd14;

	logic [3:0] state_q;

	// Ellipse state
	logic signed [C-1:0]   ox_q, oy_q;
	logic [R-1:0]          ry_q;
	logic [R2W-1:0]        rx2_q, ry2_q;
	logic [XW-1:0]         x_q;
	logic signed [XW-1:0]  y_q;
	logic signed [DW-1:0]  d_q;
	logic                  r2_q;

	// Datapath temporaries
	logic signed [PW-1:0]  mq_q, t_q;
	logic signed [DW-1:0]  acc_q;
	logic                  out_valid_q;

	logic signed [AW-1:0]  mul_a;
	logic signed [BW-1:0]  mul_b;
	logic signed [AW-1:0]  a_rx2, a_ry2, a_mq, a_rxh, a_ry;
	logic signed [BW-1:0]  b_x, b_y, b_2x3, b_2x2, b_tx, b_2m2y, b_3m2y, b_ym1, b_rxh, b_ry;
	logic signed [DW-1:0]  mq_ext, t_ext, rx2_ext, ry2_ext, d_step;
	logic                  neg, pos, sel, slot_free, emit, is_less;
	logic [XW-1:0]         x_next;
	logic signed [XW-1:0]  y_next;
	logic signed [SW-1:0]  ox_s, oy_s, x_s, y_s;
	logic signed [SW-1:0]  px_sum, px_dif, py_sum, py_dif;

	assign a_rx2 = {{(AW - R2W){1'b0}}, rx2_q};
	assign a_ry2 = {{(AW - R2W){1'b0}}, ry2_q};
	assign a_mq  = mq_q[AW-1:0];
	assign a_rxh = {{(AW - R){1'b0}}, head_radius_x};
	assign a_ry  = {{(AW - R){1'b0}}, ry_q};

	assign b_x    = {{(BW - XW){1'b0}}, x_q};
	assign b_y    = {{(BW - XW){y_q[XW-1]}}, y_q};
	assign b_2x3  = (b_x <<< 1) + BW'(3);
	assign b_2x2  = (b_x <<< 1) + BW'(2);
	assign b_tx   = (b_x <<< 1) + BW'(1);
	assign b_2m2y = BW'(2) - (b_y <<< 1);
	assign b_3m2y = BW'(3) - (b_y <<< 1);
	assign b_ym1  = b_y - BW'(1);
	assign b_rxh  = {{(BW - R){1'b0}}, head_radius_x};
	assign b_ry   = {{(BW - R){1'b0}}, ry_q};

	assign mq_ext  = {{(DW - PW){mq_q[PW-1]}}, mq_q};
	assign t_ext   = {{(DW - PW){t_q[PW-1]}}, t_q};
	assign rx2_ext = {{(DW - R2W){1'b0}}, rx2_q};
	assign ry2_ext = {{(DW - R2W){1'b0}}, ry2_q};

	// Region test: ry^2*x (held) against rx^2*y (fresh product)
	assign is_less = (t_q < mq_q);

	// Step update: t holds the first increment, mq the second
	assign neg    = d_q[DW-1];
	assign pos    = !neg && (d_q != '0);
	assign sel    = r2_q ? !pos : !neg;
	assign d_step = d_q + (t_ext <<< 2) + (sel ? (mq_ext <<< 2) : '0);
	assign x_next = (!r2_q || sel) ? x_q + 1'b1 : x_q;
	assign y_next = (r2_q || sel) ? y_q - XW'(1) : y_q;

	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = ((state_q == ST_UP3) || (state_q == ST_FIN)) && slot_free;
	assign pop       = (state_q == ST_IDLE) && head_valid;

	assign status.idle = (state_q == ST_IDLE);
	assign status.emit = emit;

	// Mirrored points of the current (x,y)
	assign ox_s   = {{(SW - C){ox_q[C-1]}}, ox_q};
	assign oy_s   = {{(SW - C){oy_q[C-1]}}, oy_q};
	assign x_s    = {{(SW - XW){1'b0}}, x_q};
	assign y_s    = {{(SW - XW){y_q[XW-1]}}, y_q};
	assign px_sum = ox_s + x_s;
	assign px_dif = ox_s - x_s;
	assign py_sum = oy_s + y_s;
	assign py_dif = oy_s - y_s;

	// Operand select of the shared multiplier; product lands in mq_q next cycle
	always_comb begin
		mul_a = a_rx2;
		mul_b = b_ry;
		unique case (state_q)
			ST_IDLE: begin
				if (head_kind == KIND_START) begin
					mul_a = a_rxh;
					mul_b = b_rxh;
				end else if (r2_q) begin
					mul_a = a_rx2;
					mul_b = b_3m2y;
				end else begin
					mul_a = a_ry2;
					mul_b = b_x;
				end
			end
			ST_LD1: begin
				mul_a = a_ry;
				mul_b = b_ry;
			end
			ST_LD2: begin
				mul_a = a_rx2;
				mul_b = b_ry;
			end
			ST_CK2: begin
				mul_a = a_rx2;
				mul_b = b_y;
			end
			ST_CK3: begin
				mul_a = a_ry2;
				mul_b = is_less ? b_2x3 : b_tx;
			end
			ST_EN2: begin
				mul_a = a_mq;
				mul_b = b_tx;
			end
			ST_EN3: begin
				mul_a = a_rx2;
				mul_b = b_ym1;
			end
			ST_EN4: begin
				mul_a = a_mq;
				mul_b = b_ym1;
			end
			ST_EN5: begin
				mul_a = a_rx2;
				mul_b = b_ry;
			end
			ST_EN6: begin
				mul_a = a_mq;
				mul_b = b_ry;
			end
			ST_EN7: begin
				mul_a = a_rx2;
				mul_b = b_3m2y;
			end
			ST_UP2, ST_UP3: begin
				mul_a = r2_q ? a_ry2 : a_rx2;
				mul_b = r2_q ? b_2x2 : b_2m2y;
			end
			default: begin
				mul_a = a_rx2;
				mul_b = b_ry;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ox_q        <= '0;
			oy_q        <= '0;
			ry_q        <= '0;
			rx2_q       <= '0;
			ry2_q       <= '0;
			x_q         <= '0;
			y_q         <= '1;
			d_q         <= '0;
			r2_q        <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (head_kind == KIND_START) begin
							ox_q    <= head_center_x;
							oy_q    <= head_center_y;
							ry_q    <= head_radius_y;
							x_q     <= '0;
							y_q     <= {1'b0, head_radius_y};
							r2_q    <= 1'b0;
							state_q <= ST_LD1;
						end else if (y_q[XW-1]) begin
							state_q <= ST_FIN;
						end else if (r2_q) begin
							state_q <= ST_UP2;
						end else begin
							state_q <= ST_CK2;
						end
					end
				end
				ST_LD1: begin
					rx2_q   <= mq_q[R2W-1:0];
					state_q <= ST_LD2;
				end
				ST_LD2: begin
					ry2_q   <= mq_q[R2W-1:0];
					state_q <= ST_LD3;
				end
				ST_LD3: begin
					d_q     <= (ry2_ext <<< 2) - (mq_ext <<< 2) + rx2_ext;
					state_q <= ST_IDLE;
				end
				ST_CK2: state_q <= ST_CK3;
				ST_CK3: state_q <= is_less ? ST_UP2 : ST_EN2;
				ST_EN2: state_q <= ST_EN3;
				ST_EN3: state_q <= ST_EN4;
				ST_EN4: state_q <= ST_EN5;
				ST_EN5: state_q <= ST_EN6;
				ST_EN6: state_q <= ST_EN7;
				ST_EN7: begin
					d_q     <= acc_q - (mq_ext <<< 2);
					r2_q    <= 1'b1;
					state_q <= ST_UP2;
				end
				ST_UP2: state_q <= ST_UP3;
				ST_UP3: begin
					if (slot_free) begin
						d_q     <= d_step;
						x_q     <= x_next;
						y_q     <= y_next;
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mq_q <= mul_a * mul_b;
		if ((state_q == ST_CK2) || (state_q == ST_UP2)) begin
			t_q <= mq_q;
		end
		if (state_q == ST_EN3) begin
			acc_q <= mq_ext;
		end else if (state_q == ST_EN5) begin
			acc_q <= acc_q + (mq_ext <<< 2);
		end
		if (emit) begin
			if (state_q == ST_FIN) begin
				q1_x         <= '0;
				q1_y         <= '0;
				q2_x         <= '0;
				q2_y         <= '0;
				q3_x         <= '0;
				q3_y         <= '0;
				q4_x         <= '0;
				q4_y         <= '0;
				points_valid <= 1'b0;
				done_res     <= 1'b1;
			end else begin
				q1_x         <= px_sum[OW-1:0];
				q1_y         <= py_sum[OW-1:0];
				q2_x         <= px_dif[OW-1:0];
				q2_y         <= py_sum[OW-1:0];
				q3_x         <= px_dif[OW-1:0];
				q3_y         <= py_dif[OW-1:0];
				q4_x         <= px_sum[OW-1:0];
				q4_y         <= py_dif[OW-1:0];
				points_valid <= 1'b1;
				done_res     <= r2_q && y_next[XW-1];
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sim/tb_midpoint_ellipse_rasterizer_core.sv -----
`timescale 1ns / 100ps

module tb_midpoint_ellipse_rasterizer_core;

	import mer_pkg::*;

	localparam int CW = 11;          // center width
	localparam int RW = 10;          // radius width
	localparam int OW = CW + 1;      // point width
	localparam int RAND_ITEMS = 1750;
	localparam int PHASE_ITEMS = 440;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 40;
	localparam int SMALL_RADIUS = 12;

	// One input transaction, as the sender offers it
	typedef struct packed {
		kind_t                 op;
		logic signed [CW-1:0]  cx;
		logic signed [CW-1:0]  cy;
		logic [RW-1:0]         rx;
		logic [RW-1:0]         ry;
	} ellipse_cmd_t;

	// One output transaction: four mirrored points plus flags
	typedef struct packed {
		logic signed [OW-1:0] q1_x;
		logic signed [OW-1:0] q1_y;
		logic signed [OW-1:0] q2_x;
		logic signed [OW-1:0] q2_y;
		logic signed [OW-1:0] q3_x;
		logic signed [OW-1:0] q3_y;
		logic signed [OW-1:0] q4_x;
		logic signed [OW-1:0] q4_y;
		logic                 points_valid;
		logic                 done_res;
	} arc_result_t;

	// Directed table row; fixed_res is used in place of the prediction when pinned is set
	typedef struct packed {
		ellipse_cmd_t cmd;
		logic         pinned;
		arc_result_t  fixed_res;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic signed [CW-1:0] center_x = '0;
	logic signed [CW-1:0] center_y = '0;
	logic [RW-1:0] radius_x = '0;
	logic [RW-1:0] radius_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OW-1:0] q1_x, q1_y, q2_x, q2_y, q3_x, q3_y, q4_x, q4_y;
	logic points_valid;
	logic done_res;

	midpoint_ellipse_rasterizer_core #(
		.COORD_BITS(CW),
		.RADIUS_BITS(RW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.center_x(center_x),
		.center_y(center_y),
		.radius_x(radius_x),
		.radius_y(radius_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.q1_x(q1_x),
		.q1_y(q1_y),
		.q2_x(q2_x),
		.q2_y(q2_y),
		.q3_x(q3_x),
		.q3_y(q3_y),
		.q4_x(q4_x),
		.q4_y(q4_y),
		.points_valid(points_valid),
		.done_res(done_res)
	);

	// Predicted arc state: center, squared semi-axes, current point,
	// decision value scaled by four, and whether the steep part has begun
	longint ctr_x, ctr_y;
	longint rx_sq, ry_sq;
	longint cur_x, cur_y;
	longint dec4;
	bit     steep_part;

	arc_result_t pts_pending[$];   // expected point sets, oldest first
	dir_row_t    dir_table[$];
	int          items_sent;
	int          fail_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the handshake hangs
	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Build the four mirrored points, each wrapped to the output width
	function automatic arc_result_t mirror_pts(longint xp, longint xm, longint yp, longint ym,
			bit v, bit d);
		arc_result_t r;
		r.q1_x = xp[OW-1:0];
		r.q1_y = yp[OW-1:0];
		r.q2_x = xm[OW-1:0];
		r.q2_y = yp[OW-1:0];
		r.q3_x = xm[OW-1:0];
		r.q3_y = ym[OW-1:0];
		r.q4_x = xp[OW-1:0];
		r.q4_y = ym[OW-1:0];
		r.points_valid = v;
		r.done_res = d;
		return r;
	endfunction

	function automatic string pts_str(arc_result_t r);
		return $sformatf("(%0d,%0d) (%0d,%0d) (%0d,%0d) (%0d,%0d) valid=%0b done=%0b",
			r.q1_x, r.q1_y, r.q2_x, r.q2_y, r.q3_x, r.q3_y, r.q4_x, r.q4_y,
			r.points_valid, r.done_res);
	endfunction

	function automatic dir_row_t load_row(int cx, int cy, int rx, int ry);
		dir_row_t row;
		row = '0;
		row.cmd.op = KIND_START;
		row.cmd.cx = CW'(cx);
		row.cmd.cy = CW'(cy);
		row.cmd.rx = RW'(rx);
		row.cmd.ry = RW'(ry);
		return row;
	endfunction

	function automatic dir_row_t step_row(bit pinned, arc_result_t res);
		dir_row_t row;
		row = '0;
		row.cmd.op = KIND_STEP;
		row.pinned = pinned;
		row.fixed_res = res;
		return row;
	endfunction

	// Advance the predicted rasterizer by one accepted transaction
	task automatic trace_arc(input ellipse_cmd_t c, output bit emits, output arc_result_t r);
		longint tx, ym1;
		begin
			emits = 1'b0;
			r = '0;
			if (c.op == KIND_START) begin
				// Load geometry and seed the flat-part decision value
				ctr_x = longint'(c.cx);
				ctr_y = longint'(c.cy);
				rx_sq = longint'(c.rx) * longint'(c.rx);
				ry_sq = longint'(c.ry) * longint'(c.ry);
				cur_x = 0;
				cur_y = longint'(c.ry);
				dec4 = 4 * ry_sq - 4 * rx_sq * longint'(c.ry) + rx_sq;
				steep_part = 1'b0;
			end else if (cur_y < 0) begin
				// Arc finished (or never started): report done, no points
				emits = 1'b1;
				r.done_res = 1'b1;
			end else begin
				emits = 1'b1;
				// Switch regions once the slope reaches -1; reseed the decision value
				if (!steep_part && !(ry_sq * cur_x < rx_sq * cur_y)) begin
					tx = 2 * cur_x + 1;
					ym1 = cur_y - 1;
					dec4 = ry_sq * tx * tx + 4 * rx_sq * ym1 * ym1 - 4 * rx_sq * ry_sq;
					steep_part = 1'b1;
				end
				r = mirror_pts(ctr_x + cur_x, ctr_x - cur_x, ctr_y + cur_y, ctr_y - cur_y,
					1'b1, 1'b0);
				if (!steep_part) begin
					if (dec4 < 0) begin
						dec4 += 4 * ry_sq * (2 * cur_x + 3);
					end else begin
						dec4 += 4 * ry_sq * (2 * cur_x + 3) + 4 * rx_sq * (2 - 2 * cur_y);
						cur_y--;
					end
					cur_x++;
				end else begin
					if (dec4 > 0) begin
						dec4 += 4 * rx_sq * (3 - 2 * cur_y);
					end else begin
						dec4 += 4 * ry_sq * (2 * cur_x + 2) + 4 * rx_sq * (3 - 2 * cur_y);
						cur_x++;
					end
					cur_y--;
				end
				r.done_res = steep_part && cur_y < 0;
			end
		end
	endtask

	// Offer one transaction, hold it until accepted, then record what it should produce
	task automatic offer_cmd(input ellipse_cmd_t c, input bit pinned, input arc_result_t fixed);
		bit emits;
		arc_result_t r;
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			operation <= c.op;
			center_x <= c.cx;
			center_y <= c.cy;
			radius_x <= c.rx;
			radius_y <= c.ry;
			do @(posedge clk); while (in_stall);
			trace_arc(c, emits, r);
			if (emits)
				pts_pending.push_back(pinned ? fixed : r);
			items_sent++;
		end
	endtask

	// Receiver: check every accepted result, then pick the stall for the next cycle
	initial begin
		int hold_left;
		arc_result_t got, want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got = '{q1_x, q1_y, q2_x, q2_y, q3_x, q3_y, q4_x, q4_y, points_valid, done_res};
				if (pts_pending.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %s", pts_str(got));
				end else begin
					want = pts_pending.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: want %s", pts_str(want));
							$display("          got  %s", pts_str(got));
						end
					end
				end
			end
			// A hold-off request keeps the output stalled long enough to back up the input
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Stimulus: reset, directed table, then random arcs across the idling phases
	initial begin
		ellipse_cmd_t cmd;
		int base, cap, n, extra;
		bit big;
		items_sent = 0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		ctr_x = 0;
		ctr_y = 0;
		rx_sq = 0;
		ry_sq = 0;
		cur_x = 0;
		cur_y = -1;
		dec4 = 0;
		steep_part = 1'b0;

		// Step before any start: done, no points
		dir_table.push_back(step_row(1'b1, mirror_pts(0, 0, 0, 0, 1'b0, 1'b1)));
		// Both semi-axes zero at the corner of the center range: one point, then done
		dir_table.push_back(load_row(-1024, 1023, 0, 0));
		dir_table.push_back(step_row(1'b1, mirror_pts(-1024, -1024, 1023, 1023, 1'b1, 1'b1)));
		// Step after the arc ends
		dir_table.push_back(step_row(1'b1, mirror_pts(0, 0, 0, 0, 1'b0, 1'b1)));
		// Largest ellipse at the opposite corner: first point is the top of the arc
		dir_table.push_back(load_row(1023, -1024, 1023, 1023));
		dir_table.push_back(step_row(1'b1, mirror_pts(1023, 1023, -1, -2047, 1'b1, 1'b0)));
		dir_table.push_back(step_row(1'b0, '0));
		dir_table.push_back(step_row(1'b0, '0));
		// Restart mid-arc with a vertical line (zero horizontal semi-axis)
		dir_table.push_back(load_row(5, -7, 0, 3));
		repeat (5) dir_table.push_back(step_row(1'b0, '0));
		// Horizontal line (zero vertical semi-axis)
		dir_table.push_back(load_row(-300, 200, 4, 0));
		repeat (2) dir_table.push_back(step_row(1'b0, '0));
		// Flat ellipse that crosses from the flat part into the steep part
		dir_table.push_back(load_row(0, 0, 6, 2));
		repeat (6) dir_table.push_back(step_row(1'b0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			offer_cmd(dir_table[i].cmd, dir_table[i].pinned, dir_table[i].fixed_res);

		// Random arcs; open with a long receiver hold-off while the sender keeps pushing
		base = items_sent;
		hold_req = 1'b1;
		while (items_sent < base + RAND_ITEMS) begin
			case ((items_sent - base) / PHASE_ITEMS)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 81;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 81;
				end
				default: begin
					send_idle_pct = 16;
					recv_stall_pct = 16;
				end
			endcase

			// Mostly small radii so arcs finish; now and then a full-range one, cut short
			big = ($urandom_range(99) < 12);
			cmd.op = KIND_START;
			cmd.cx = CW'($urandom);
			cmd.cy = CW'($urandom);
			cmd.rx = big ? RW'($urandom_range(0, 1023)) : RW'($urandom_range(0, SMALL_RADIUS));
			cmd.ry = big ? RW'($urandom_range(0, 1023)) : RW'($urandom_range(0, SMALL_RADIUS));
			offer_cmd(cmd, 1'b0, '0);

			if (big)
				cap = $urandom_range(1, 30);
			else if ($urandom_range(99) < 10)
				cap = $urandom_range(0, 8);     // abandon the arc early
			else
				cap = 1 << 20;

			// Step fields carry junk; the block must ignore them
			n = 0;
			while (cur_y >= 0 && n < cap) begin
				cmd.op = KIND_STEP;
				cmd.cx = CW'($urandom);
				cmd.cy = CW'($urandom);
				cmd.rx = RW'($urandom);
				cmd.ry = RW'($urandom);
				offer_cmd(cmd, 1'b0, '0);
				n++;
			end

			// A few steps past the end of the arc
			if (cur_y < 0) begin
				extra = $urandom_range(0, 2);
				repeat (extra) begin
					cmd.op = KIND_STEP;
					cmd.cx = CW'($urandom);
					cmd.cy = CW'($urandom);
					cmd.rx = RW'($urandom);
					cmd.ry = RW'($urandom);
					offer_cmd(cmd, 1'b0, '0);
				end
			end
		end

		// Drain: wait for every expected result, then watch for strays
		in_valid <= 1'b0;
		while (pts_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pts_pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
